// File: design/opvd_pkg.sv
// Shared types, table and constants of the OBD-II PID value decoder.
package opvd_pkg;

  localparam int PID_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 4;
  localparam int ROW_W   = 4;
  localparam int VALUE_W = 25;
  localparam int NUM_W   = 18;   // signed numerator before scaling
  localparam int ROWS    = 15;

  localparam logic [ROW_W-1:0] NO_ROW = 4'd15;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_SHORT   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    F_DTC, F_PCT, F_TEMP, F_TRIM, F_PRESS, F_DIRECT, F_RPM, F_TIMING,
    F_MAF, F_O2, F_RUN
  } kind_e;

  // Divisor applied to the numerator in the back end
  typedef enum logic [2:0] {
    DIV_1, DIV_2, DIV_4, DIV_128, DIV_100, DIV_200, DIV_255
  } div_e;

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic [CNT_W-1:0] need;
    kind_e            kind;
  } row_t;

  localparam row_t ROW_TABLE [ROWS] = '{
    '{8'h01, 4'd4, F_DTC},    '{8'h04, 4'd1, F_PCT},    '{8'h05, 4'd1, F_TEMP},
    '{8'h06, 4'd1, F_TRIM},   '{8'h07, 4'd1, F_TRIM},   '{8'h0A, 4'd1, F_PRESS},
    '{8'h0B, 4'd1, F_DIRECT}, '{8'h0C, 4'd2, F_RPM},    '{8'h0D, 4'd1, F_DIRECT},
    '{8'h0E, 4'd1, F_TIMING}, '{8'h0F, 4'd1, F_TEMP},   '{8'h10, 4'd2, F_MAF},
    '{8'h11, 4'd1, F_PCT},    '{8'h14, 4'd1, F_O2},     '{8'h1F, 4'd2, F_RUN}
  };

  // Classified item handed from the front end to the back end
  typedef struct packed {
    status_e                 status;
    logic [PID_W-1:0]        pid;
    logic [ROW_W-1:0]        row;
    logic signed [NUM_W-1:0] num;
    div_e                    div;
  } item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [VALUE_W-1:0] value;
    logic [PID_W-1:0]          pid;
    logic [ROW_W-1:0]          row;
  } result_t;

endpackage

// File: design/opvd_front.sv
// Front end: table match, length check and numerator/divisor selection.
module opvd_front (
  input  logic [opvd_pkg::PID_W-1:0]  pid_i,
  input  logic [opvd_pkg::BYTE_W-1:0] byte_a_i,
  input  logic [opvd_pkg::BYTE_W-1:0] byte_b_i,
  input  logic [opvd_pkg::CNT_W-1:0]  rx_len_i,
  output opvd_pkg::item_t             item_o
);

  localparam int NW = opvd_pkg::NUM_W;

  localparam logic signed [NW-1:0] C3   = NW'(3);
  localparam logic signed [NW-1:0] C40  = NW'(40);
  localparam logic signed [NW-1:0] C100 = NW'(100);
  localparam logic signed [NW-1:0] C128 = NW'(128);
  localparam logic signed [NW-1:0] C7F  = NW'(8'h7F);

  logic                            hit;
  logic [opvd_pkg::ROW_W-1:0]      row;
  logic [opvd_pkg::CNT_W-1:0]      need;
  opvd_pkg::kind_e                 kind;
  logic signed [NW-1:0]            a_s;
  logic signed [NW-1:0]            w_s;

  assign a_s = $signed(NW'(byte_a_i));
  assign w_s = $signed(NW'({byte_a_i, byte_b_i}));

  // PIDs in the table are unique, so the compares are independent
  always_comb begin
    hit  = 1'b0;
    row  = opvd_pkg::NO_ROW;
    need = '0;
    kind = opvd_pkg::F_DTC;
    for (int i = 0; i < opvd_pkg::ROWS; i++) begin
      if (!hit && opvd_pkg::ROW_TABLE[i].pid == pid_i) begin
        hit  = 1'b1;
        row  = opvd_pkg::ROW_W'(i);
        need = opvd_pkg::ROW_TABLE[i].need;
        kind = opvd_pkg::ROW_TABLE[i].kind;
      end
    end
  end

  always_comb begin
    item_o.pid = pid_i;
    item_o.row = row;
    if (!hit) begin
      item_o.status = opvd_pkg::ST_UNKNOWN;
    end else if (rx_len_i < need) begin
      item_o.status = opvd_pkg::ST_SHORT;
    end else begin
      item_o.status = opvd_pkg::ST_OK;
    end

    case (kind)
      opvd_pkg::F_DTC: begin
        item_o.num = a_s & C7F;
        item_o.div = opvd_pkg::DIV_1;
      end
      opvd_pkg::F_PCT: begin
        item_o.num = a_s * C100;
        item_o.div = opvd_pkg::DIV_255;
      end
      opvd_pkg::F_TEMP: begin
        item_o.num = a_s - C40;
        item_o.div = opvd_pkg::DIV_1;
      end
      opvd_pkg::F_TRIM: begin
        item_o.num = (a_s - C128) * C100;
        item_o.div = opvd_pkg::DIV_128;
      end
      opvd_pkg::F_PRESS: begin
        item_o.num = a_s * C3;
        item_o.div = opvd_pkg::DIV_1;
      end
      opvd_pkg::F_DIRECT: begin
        item_o.num = a_s;
        item_o.div = opvd_pkg::DIV_1;
      end
      opvd_pkg::F_RPM: begin
        item_o.num = w_s;
        item_o.div = opvd_pkg::DIV_4;
      end
      opvd_pkg::F_TIMING: begin
        item_o.num = a_s - C128;
        item_o.div = opvd_pkg::DIV_2;
      end
      opvd_pkg::F_MAF: begin
        item_o.num = w_s;
        item_o.div = opvd_pkg::DIV_100;
      end
      opvd_pkg::F_O2: begin
        item_o.num = a_s;
        item_o.div = opvd_pkg::DIV_200;
      end
      default: begin
        item_o.num = w_s;
        item_o.div = opvd_pkg::DIV_1;
      end
    endcase
  end

endmodule

// File: design/opvd_queue.sv
// Short FIFO of classified items between the front end and the back end.
module opvd_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  opvd_pkg::item_t wr_item_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output opvd_pkg::item_t rd_item_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  opvd_pkg::item_t mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;
  logic            push, pop;

  assign wr_ready_o = (count_q != CW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// File: design/opvd_back.sv
// Back end: three-stage scale, constant divide with rounding, and saturation.
module opvd_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  opvd_pkg::item_t   item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output opvd_pkg::result_t result_o
);

  localparam int SXW = opvd_pkg::NUM_W + FRAC_BITS;  // signed scaled numerator
  localparam int UXW = 16 + FRAC_BITS;               // scaled numerator, divide path
  localparam int MW  = UXW - 6;                      // reciprocal and quotient
  localparam int PRW = UXW + MW;
  localparam int SW  = (SXW + 2 > opvd_pkg::VALUE_W + 2) ? SXW + 2 : opvd_pkg::VALUE_W + 2;

  localparam logic [MW-1:0] M100 = MW'((longint'(1) << UXW) / 100);
  localparam logic [MW-1:0] M200 = MW'((longint'(1) << UXW) / 200);
  localparam logic [MW-1:0] M255 = MW'((longint'(1) << UXW) / 255);

  localparam logic signed [SW-1:0] VMAX = (SW'(1) <<< (opvd_pkg::VALUE_W - 1)) - SW'(1);
  localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

  function automatic logic [7:0] div_value(opvd_pkg::div_e div);
    logic [7:0] d;
    case (div)
      opvd_pkg::DIV_100: d = 8'd100;
      opvd_pkg::DIV_200: d = 8'd200;
      default:           d = 8'd255;
    endcase
    return d;
  endfunction

  function automatic logic is_shift(opvd_pkg::div_e div);
    logic s;
    case (div)
      opvd_pkg::DIV_1, opvd_pkg::DIV_2, opvd_pkg::DIV_4, opvd_pkg::DIV_128: s = 1'b1;
      default: s = 1'b0;
    endcase
    return s;
  endfunction

  logic adv;

  // stage 1
  logic                    v1_q;
  opvd_pkg::status_e       st1_q;
  logic [opvd_pkg::PID_W-1:0] pid1_q;
  logic [opvd_pkg::ROW_W-1:0] row1_q;
  opvd_pkg::div_e          div1_q;
  logic [UXW-1:0]          x1_q;
  logic [PRW-1:0]          prod_q, prod_d;
  logic signed [SXW:0]     sh1_q, sh_d;

  // stage 2
  logic                    v2_q;
  opvd_pkg::status_e       st2_q;
  logic [opvd_pkg::PID_W-1:0] pid2_q;
  logic [opvd_pkg::ROW_W-1:0] row2_q;
  opvd_pkg::div_e          div2_q;
  logic signed [SXW:0]     sh2_q;
  logic [MW-1:0]           quo_q, quo_d;
  logic [7:0]              rem_q, rem_d;

  // stage 3
  logic                    v3_q;
  opvd_pkg::result_t       res_q, res_d;

  logic signed [SXW-1:0]   xs;
  logic [UXW-1:0]          xu;
  logic signed [SXW:0]     half;
  logic [2:0]              shamt;
  logic [MW-1:0]           m_sel;
  logic [MW-1:0]           q_est;
  logic [UXW-1:0]          r_full;
  logic [9:0]              r_est;
  logic [7:0]              d2, d3;
  logic                    rnd;
  logic signed [SW-1:0]    rec, pick, sat;

  assign adv          = !v3_q || out_ready_i;
  assign item_ready_o = adv;
  assign out_valid_o  = v3_q;
  assign result_o     = res_q;

  // Stage 1: scale by 2^FRAC_BITS, shift path for powers of two, multiply by reciprocal
  always_comb begin
    xs = SXW'(item_i.num) <<< FRAC_BITS;
    xu = xs[UXW-1:0];
    case (item_i.div)
      opvd_pkg::DIV_2: begin
        half  = (SXW+1)'(1);
        shamt = 3'd1;
      end
      opvd_pkg::DIV_4: begin
        half  = (SXW+1)'(2);
        shamt = 3'd2;
      end
      opvd_pkg::DIV_128: begin
        half  = (SXW+1)'(64);
        shamt = 3'd7;
      end
      default: begin
        half  = '0;
        shamt = 3'd0;
      end
    endcase
    sh_d = ((SXW+1)'(xs) + half) >>> shamt;
    case (item_i.div)
      opvd_pkg::DIV_100: m_sel = M100;
      opvd_pkg::DIV_200: m_sel = M200;
      default:           m_sel = M255;
    endcase
    prod_d = PRW'(xu) * PRW'(m_sel);
  end

  // Stage 2: quotient estimate is low by at most one; fix it with one compare
  always_comb begin
    d2     = div_value(div1_q);
    q_est  = prod_q[PRW-1:UXW];
    r_full = x1_q - UXW'(q_est) * UXW'(d2);
    r_est  = r_full[9:0];
    if (r_est >= {2'b00, d2}) begin
      quo_d = q_est + MW'(1);
      rem_d = 8'(r_est - {2'b00, d2});
    end else begin
      quo_d = q_est;
      rem_d = r_est[7:0];
    end
  end

  // Stage 3: round half up, select path, saturate, zero on error
  always_comb begin
    d3   = div_value(div2_q);
    rnd  = ({1'b0, rem_q, 1'b0} >= {2'b00, d3});
    rec  = $signed(SW'(quo_q)) + $signed(SW'(rnd));
    pick = is_shift(div2_q) ? SW'(sh2_q) : rec;
    if (pick > VMAX) begin
      sat = VMAX;
    end else if (pick < VMIN) begin
      sat = VMIN;
    end else begin
      sat = pick;
    end
    res_d.status = st2_q;
    res_d.pid    = pid2_q;
    res_d.row    = row2_q;
    res_d.value  = (st2_q == opvd_pkg::ST_OK) ? opvd_pkg::VALUE_W'(sat) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= item_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // All stages advance together; the queue in front absorbs the stall
  always_ff @(posedge clk_i) begin
    if (adv) begin
      st1_q  <= item_i.status;
      pid1_q <= item_i.pid;
      row1_q <= item_i.row;
      div1_q <= item_i.div;
      x1_q   <= xu;
      prod_q <= prod_d;
      sh1_q  <= sh_d;

      st2_q  <= st1_q;
      pid2_q <= pid1_q;
      row2_q <= row1_q;
      div2_q <= div1_q;
      sh2_q  <= sh1_q;
      quo_q  <= quo_d;
      rem_q  <= rem_d;

      res_q  <= res_d;
    end
  end

endmodule

// File: design/obd_pid_value_decoder.sv
// Top level of the OBD-II PID value decoder: stream ports, front end, queue, back end.
//
//  channel   direction  tdata (low bit first)                         tuser
//  s_axis    in         pid[7:0] byte_a[15:8] byte_b[23:16]             -
//                       rx_len[27:24], zero [31:28]
//  m_axis    out        value_q8[24:0] pid_echo[32:25] sensor_row[36:33]  status[1:0]
//                       zero [39:37]
//
//  One item per cycle sustained while m_axis_tready is high; m_axis_tvalid rises once an
//  item has passed the queue, the scale and reciprocal multiply, correction and rounding.
//  Reset clears the queue pointers and count and the pipeline valid flags only.
//  While m_axis stalls, the three back-end stages hold and the queue keeps taking
//  items until it is full.
module obd_pid_value_decoder #(
  parameter int FRAC_BITS   = 8,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pid, byte_a, byte_b, rx_len
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // value_q8, pid_echo, sensor_row
  output logic [1:0]  m_axis_tuser    // status
);

  opvd_pkg::item_t   fr_item;
  opvd_pkg::item_t   q_item;
  logic              q_valid;
  logic              q_ready;
  opvd_pkg::result_t result;

  opvd_front u_front (
    .pid_i    (s_axis_tdata[7:0]),
    .byte_a_i (s_axis_tdata[15:8]),
    .byte_b_i (s_axis_tdata[23:16]),
    .rx_len_i (s_axis_tdata[27:24]),
    .item_o   (fr_item)
  );

  opvd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s_axis_tvalid),
    .wr_ready_o (s_axis_tready),
    .wr_item_i  (fr_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  opvd_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_o     (result)
  );

  assign m_axis_tdata = {3'b000, result.row, result.pid, result.value};
  assign m_axis_tuser = result.status;

endmodule
